[rtl/hrlf_pkg.sv]
// Shared constants, types and pattern tables of the HTTP request length framer.
`default_nettype none

package hrlf_pkg;

  localparam int unsigned DATA_W   = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned CLEN_W   = 32;
  localparam int unsigned HLEN_W   = 24;
  localparam int unsigned MAX_W    = 24;
  localparam int unsigned SCAN_W   = 5;

  localparam logic [MAX_W-1:0] MAX_RESET = 24'd1048576;

  localparam logic [DATA_W-1:0] CH_CR    = 8'h0D;
  localparam logic [DATA_W-1:0] CH_LF    = 8'h0A;
  localparam logic [DATA_W-1:0] CH_SP    = 8'h20;
  localparam logic [DATA_W-1:0] CH_TAB   = 8'h09;
  localparam logic [DATA_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [DATA_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [DATA_W-1:0] CH_NINE  = 8'h39;
  localparam logic [DATA_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [DATA_W-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [DATA_W-1:0] CASE_BIT = 8'h20;

  // Line scan codes: values below LS_BLANKS are positions inside "content-length:"
  localparam logic [SCAN_W-1:0] LS_START  = 5'd0;
  localparam logic [SCAN_W-1:0] LS_BLANKS = 5'd15;
  localparam logic [SCAN_W-1:0] LS_SIGN   = 5'd16;
  localparam logic [SCAN_W-1:0] LS_DIGITS = 5'd17;
  localparam logic [SCAN_W-1:0] LS_REST   = 5'd18;

  localparam logic [SCAN_W-1:0] TE_LEN = 5'd19;

  typedef enum logic [STATUS_W-1:0] {
    ST_NEED_MORE = 3'd0,
    ST_COMPLETE  = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_CONFLICT  = 3'd3,
    ST_ENCODING  = 3'd4,
    ST_IGNORED   = 3'd5
  } hrlf_status_e;

  typedef struct packed {
    logic fire;      // a beat is processed this cycle
    logic clear;     // start of a new request
    logic scan_en;   // the beat is a header byte that gets parsed
    logic after_cr;  // previous header byte was CR
  } hrlf_scan_ctl_t;

  typedef struct packed {
    logic found;
    logic conflict;
  } hrlf_len_flags_t;

  function automatic logic [DATA_W-1:0] lower_byte(input logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] r;
    r = b;
    if (b >= CH_UP_A && b <= CH_UP_Z) begin
      r = b | CASE_BIT;
    end
    return r;
  endfunction

  // "content-length:"
  function automatic logic [DATA_W-1:0] cl_char(input logic [3:0] idx);
    logic [DATA_W-1:0] c;
    unique case (idx)
      4'd0:    c = 8'h63;
      4'd1:    c = 8'h6F;
      4'd2:    c = 8'h6E;
      4'd3:    c = 8'h74;
      4'd4:    c = 8'h65;
      4'd5:    c = 8'h6E;
      4'd6:    c = 8'h74;
      4'd7:    c = 8'h2D;
      4'd8:    c = 8'h6C;
      4'd9:    c = 8'h65;
      4'd10:   c = 8'h6E;
      4'd11:   c = 8'h67;
      4'd12:   c = 8'h74;
      4'd13:   c = 8'h68;
      4'd14:   c = 8'h3A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // CR LF "transfer-encoding"
  function automatic logic [DATA_W-1:0] te_char(input logic [SCAN_W-1:0] idx);
    logic [DATA_W-1:0] c;
    unique case (idx)
      5'd0:    c = 8'h0D;
      5'd1:    c = 8'h0A;
      5'd2:    c = 8'h74;
      5'd3:    c = 8'h72;
      5'd4:    c = 8'h61;
      5'd5:    c = 8'h6E;
      5'd6:    c = 8'h73;
      5'd7:    c = 8'h66;
      5'd8:    c = 8'h65;
      5'd9:    c = 8'h72;
      5'd10:   c = 8'h2D;
      5'd11:   c = 8'h65;
      5'd12:   c = 8'h6E;
      5'd13:   c = 8'h63;
      5'd14:   c = 8'h6F;
      5'd15:   c = 8'h64;
      5'd16:   c = 8'h69;
      5'd17:   c = 8'h6E;
      5'd18:   c = 8'h67;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

[rtl/hrlf_in_if.sv]
// Input byte channel of the framer.
`default_nettype none

interface hrlf_in_if import hrlf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] data_byte;
  logic              start_of_request;

  modport source (output valid, output data_byte, output start_of_request, input ready);
  modport sink   (input valid, input data_byte, input start_of_request, output ready);
endinterface

`default_nettype wire

[rtl/hrlf_out_if.sv]
// Result channel of the framer.
`default_nettype none

interface hrlf_out_if import hrlf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [CLEN_W-1:0]   length_value;
  logic [HLEN_W-1:0]   header_length;

  modport source (output valid, output status, output length_value, output header_length,
                  input ready);
  modport sink   (input valid, input status, input length_value, input header_length,
                  output ready);
endinterface

`default_nettype wire

[rtl/hrlf_cfg_if.sv]
// Configuration write channel carrying the request size limit.
`default_nettype none

interface hrlf_cfg_if import hrlf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [MAX_W-1:0] req_size_max;

  modport source (output valid, output req_size_max, input ready);
  modport sink   (input valid, input req_size_max, output ready);
endinterface

`default_nettype wire

[rtl/http_request_length_framer.sv]
// Top level of the HTTP/1.x request framer with Content-Length body counting.
//
//   channel | dir | beat payload                                  | handshake
//   --------+-----+-----------------------------------------------+------------
//   in_if   | in  | data_byte, start_of_request                   | valid/ready
//   out_if  | out | status, length_value, header_length           | valid/ready
//   cfg_if  | in  | req_size_max                                  | valid/ready
//
// One byte per cycle while the result side takes results; a taken byte is held in the
// input register, and the result register loads when that byte is processed
// (input register, then result register). The per-byte state update is
// compare, count and multiply-by-ten logic, which sets the rate.
// Reset clears all parse state and loads the size limit with 1048576.
// A stalled result holds in the result register; the input register then fills
// and ready drops until the result is taken.
// cfg_if is always ready; write it only while no byte is in flight.
`default_nettype none

module http_request_length_framer import hrlf_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 32,
  parameter int unsigned COUNT_BITS  = 24
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  hrlf_in_if.sink    in_if,
  hrlf_out_if.source out_if,
  hrlf_cfg_if.sink   cfg_if
);

  // Compare widths wide enough for the byte count plus one and the size limit
  localparam int unsigned CMP_W = ((COUNT_BITS > MAX_W) ? COUNT_BITS : MAX_W) + 1;
  localparam int unsigned LCW   = (LENGTH_BITS > CMP_W) ? LENGTH_BITS : CMP_W;

  typedef enum logic [1:0] {
    PH_HEAD = 2'd0,
    PH_BODY = 2'd1,
    PH_DONE = 2'd2
  } phase_e;

  // Size limit register
  logic [MAX_W-1:0] max_q;

  // Input register
  logic              in_valid_q;
  logic [DATA_W-1:0] in_byte_q;
  logic              in_start_q;

  // Result register
  logic                out_valid_q;
  hrlf_status_e        out_status_q;
  logic [CLEN_W-1:0]   out_clen_q;
  logic [HLEN_W-1:0]   out_hlen_q;

  // Framing state
  phase_e                phase_q, phase_d, phase_cur;
  logic [1:0]            blm_q, blm_d, blm_cur;
  logic [COUNT_BITS-1:0] bc_q, bc_d, bc_cur;
  logic [COUNT_BITS-1:0] heo_q, heo_d, heo_cur;

  logic                   out_free, proc;
  logic [COUNT_BITS:0]    n_wide;
  logic [COUNT_BITS-1:0]  n;
  logic [COUNT_BITS-1:0]  body_len;
  logic [CMP_W-1:0]       room;
  logic                   too_large;
  hrlf_scan_ctl_t         scan_ctl;
  hrlf_len_flags_t        len_flags_d, len_flags_q;
  logic [LENGTH_BITS-1:0] len_value_d, len_value_q;
  logic                   te_seen_d;
  hrlf_status_e           status_d;

  // Handshakes: advance when the result register is empty or being drained
  assign out_free    = !out_valid_q || out_if.ready;
  assign proc        = in_valid_q && out_free;
  assign in_if.ready = !in_valid_q || proc;
  assign cfg_if.ready = 1'b1;

  // Start of request clears framing state before the byte is used
  assign phase_cur = in_start_q ? PH_HEAD : phase_q;
  assign blm_cur   = in_start_q ? 2'd0 : blm_q;
  assign bc_cur    = in_start_q ? '0 : bc_q;
  assign heo_cur   = in_start_q ? '0 : heo_q;

  assign n_wide    = {1'b0, bc_cur} + (COUNT_BITS+1)'(1);
  assign n         = n_wide[COUNT_BITS-1:0];
  assign too_large = CMP_W'(n_wide) > CMP_W'(max_q);
  assign room      = CMP_W'(max_q) - CMP_W'(n);
  assign body_len  = n - heo_cur;

  assign scan_ctl.fire     = proc;
  assign scan_ctl.clear    = in_start_q;
  assign scan_ctl.scan_en  = (phase_cur == PH_HEAD) && !too_large;
  assign scan_ctl.after_cr = blm_cur[0];

  hrlf_line_scan #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_line_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (scan_ctl),
    .data_i    (in_byte_q),
    .flags_d_o (len_flags_d),
    .value_d_o (len_value_d),
    .flags_q_o (len_flags_q),
    .value_q_o (len_value_q)
  );

  hrlf_te_match u_te_match (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (scan_ctl),
    .data_i   (in_byte_q),
    .seen_d_o (te_seen_d)
  );

  always_comb begin
    phase_d  = phase_q;
    blm_d    = blm_q;
    bc_d     = bc_q;
    heo_d    = heo_q;
    status_d = ST_NEED_MORE;
    if (proc) begin
      phase_d = phase_cur;
      blm_d   = blm_cur;
      bc_d    = bc_cur;
      heo_d   = heo_cur;
      if (phase_cur == PH_DONE) begin
        // Answer already given: drop the byte
        status_d = ST_IGNORED;
      end else if (too_large) begin
        status_d = ST_TOO_LARGE;
        phase_d  = PH_DONE;
      end else begin
        bc_d = n;
        if (phase_cur == PH_HEAD) begin
          // Track CR LF CR LF
          if (in_byte_q == CH_CR) begin
            blm_d = (blm_cur == 2'd2) ? 2'd3 : 2'd1;
          end else if (in_byte_q == CH_LF && blm_cur == 2'd1) begin
            blm_d = 2'd2;
          end else begin
            blm_d = 2'd0;
          end
          if (in_byte_q == CH_LF && blm_cur == 2'd3) begin
            heo_d   = n;
            phase_d = PH_DONE;
            priority if (len_flags_d.conflict) begin
              status_d = ST_CONFLICT;
            end else if (te_seen_d) begin
              status_d = ST_ENCODING;
            end else if (len_flags_d.found && (LCW'(len_value_d) > LCW'(room))) begin
              status_d = ST_TOO_LARGE;
            end else if (!len_flags_d.found || len_value_d == '0) begin
              status_d = ST_COMPLETE;
            end else begin
              status_d = ST_NEED_MORE;
              phase_d  = PH_BODY;
            end
          end
        end else begin
          // Body: complete once the counted body reaches the length
          if (LCW'(body_len) >= LCW'(len_value_d)) begin
            status_d = ST_COMPLETE;
            phase_d  = PH_DONE;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEAD;
      blm_q       <= 2'd0;
      bc_q        <= '0;
      heo_q       <= '0;
      max_q       <= MAX_RESET;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      blm_q   <= blm_d;
      bc_q    <= bc_d;
      heo_q   <= heo_d;
      if (cfg_if.valid) begin
        max_q <= cfg_if.req_size_max;
      end
      if (in_if.ready) begin
        in_valid_q <= in_if.valid;
      end
      if (out_free) begin
        out_valid_q <= proc;
      end
    end
  end

  // Payload registers: load on beat, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      in_byte_q  <= in_if.data_byte;
      in_start_q <= in_if.start_of_request;
    end
    if (proc) begin
      out_status_q <= status_d;
      out_clen_q   <= len_flags_d.found ? CLEN_W'(len_value_d) : '0;
      out_hlen_q   <= HLEN_W'(heo_d);
    end
  end

  assign out_if.valid         = out_valid_q;
  assign out_if.status        = out_status_q;
  assign out_if.length_value  = out_clen_q;
  assign out_if.header_length = out_hlen_q;

  // A byte waiting in the input register holds until it is processed
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !proc |=> in_valid_q && $stable(in_byte_q) && $stable(in_start_q))
    else $error("input register lost or changed a waiting byte");

  // Body counting only runs with a nonzero accepted length
  a_body_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_BODY |-> len_flags_q.found && (len_value_q != '0))
    else $error("body phase without a nonzero content length");

  // After a final answer, bytes of the same request are reported as ignored
  a_ignore: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && !in_start_q && phase_q == PH_DONE |=> out_valid_q && out_status_q == ST_IGNORED)
    else $error("byte after a final answer was not ignored");

endmodule

`default_nettype wire

[rtl/hrlf_line_scan.sv]
// Header line scanner: Content-Length match, value accumulation and conflict tracking.
`default_nettype none

module hrlf_line_scan import hrlf_pkg::*; #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire hrlf_scan_ctl_t         ctl_i,
  input  wire logic [DATA_W-1:0]      data_i,
  output      hrlf_len_flags_t        flags_d_o,
  output      logic [LENGTH_BITS-1:0] value_d_o,
  output      hrlf_len_flags_t        flags_q_o,
  output      logic [LENGTH_BITS-1:0] value_q_o
);

  localparam int unsigned PROD_W = LENGTH_BITS + 4;

  logic [SCAN_W-1:0]      scan_q, scan_d, scan_cur, scan_nx;
  logic [LENGTH_BITS-1:0] acc_q, acc_d, acc_cur, acc_nx;
  logic                   hd_q, hd_d, hd_cur, hd_nx;
  logic                   found_q, found_d, found_cur, found_nx;
  logic [LENGTH_BITS-1:0] first_q, first_d, first_cur, first_nx;
  logic                   conf_q, conf_d, conf_cur, conf_nx;
  logic                   is_digit;
  logic [PROD_W-1:0]      prod;

  // Start of request clears the parse state before the byte is used
  assign scan_cur  = ctl_i.clear ? LS_START : scan_q;
  assign acc_cur   = ctl_i.clear ? '0 : acc_q;
  assign hd_cur    = ctl_i.clear ? 1'b0 : hd_q;
  assign found_cur = ctl_i.clear ? 1'b0 : found_q;
  assign first_cur = ctl_i.clear ? '0 : first_q;
  assign conf_cur  = ctl_i.clear ? 1'b0 : conf_q;

  assign is_digit = (data_i >= CH_ZERO) && (data_i <= CH_NINE);

  // acc * 10 + digit, with headroom to detect saturation
  assign prod = (PROD_W'(acc_cur) << 3) + (PROD_W'(acc_cur) << 1) + PROD_W'(data_i[3:0]);

  always_comb begin
    scan_nx  = scan_cur;
    acc_nx   = acc_cur;
    hd_nx    = hd_cur;
    found_nx = found_cur;
    first_nx = first_cur;
    conf_nx  = conf_cur;
    if (scan_cur < LS_BLANKS) begin
      if (lower_byte(data_i) == cl_char(scan_cur[3:0])) begin
        scan_nx = scan_cur + 5'd1;
        if (scan_nx == LS_BLANKS) begin
          acc_nx = '0;
          hd_nx  = 1'b0;
        end
      end else begin
        scan_nx = LS_REST;
      end
    end else if (scan_cur == LS_BLANKS || scan_cur == LS_SIGN || scan_cur == LS_DIGITS) begin
      if (is_digit) begin
        acc_nx  = (prod[PROD_W-1:LENGTH_BITS] != '0) ? '1 : prod[LENGTH_BITS-1:0];
        hd_nx   = 1'b1;
        scan_nx = LS_DIGITS;
      end else if (scan_cur == LS_BLANKS && (data_i == CH_SP || data_i == CH_TAB)) begin
        scan_nx = LS_BLANKS;
      end else if (scan_cur == LS_BLANKS && data_i == CH_PLUS) begin
        scan_nx = LS_SIGN;
      end else begin
        // Value ends: commit it against the first one seen
        if (scan_cur == LS_DIGITS && hd_cur) begin
          if (!found_cur) begin
            first_nx = acc_cur;
            found_nx = 1'b1;
          end else if (first_cur != acc_cur) begin
            conf_nx = 1'b1;
          end
        end
        scan_nx = LS_REST;
      end
    end else begin
      scan_nx = LS_REST;
    end
    if (data_i == CH_LF && ctl_i.after_cr) begin
      scan_nx = LS_START;
    end
  end

  always_comb begin
    scan_d  = scan_q;
    acc_d   = acc_q;
    hd_d    = hd_q;
    found_d = found_q;
    first_d = first_q;
    conf_d  = conf_q;
    if (ctl_i.fire) begin
      if (ctl_i.scan_en) begin
        scan_d  = scan_nx;
        acc_d   = acc_nx;
        hd_d    = hd_nx;
        found_d = found_nx;
        first_d = first_nx;
        conf_d  = conf_nx;
      end else begin
        scan_d  = scan_cur;
        acc_d   = acc_cur;
        hd_d    = hd_cur;
        found_d = found_cur;
        first_d = first_cur;
        conf_d  = conf_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q  <= LS_START;
      acc_q   <= '0;
      hd_q    <= 1'b0;
      found_q <= 1'b0;
      first_q <= '0;
      conf_q  <= 1'b0;
    end else begin
      scan_q  <= scan_d;
      acc_q   <= acc_d;
      hd_q    <= hd_d;
      found_q <= found_d;
      first_q <= first_d;
      conf_q  <= conf_d;
    end
  end

  assign flags_d_o = '{found: found_d, conflict: conf_d};
  assign value_d_o = first_d;
  assign flags_q_o = '{found: found_q, conflict: conf_q};
  assign value_q_o = first_q;

endmodule

`default_nettype wire

[rtl/hrlf_te_match.sv]
// Matcher for a CR LF prefixed Transfer-Encoding header name.
`default_nettype none

module hrlf_te_match import hrlf_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire hrlf_scan_ctl_t    ctl_i,
  input  wire logic [DATA_W-1:0] data_i,
  output      logic              seen_d_o
);

  logic [SCAN_W-1:0] idx_q, idx_d, idx_cur, idx_nx;

  assign idx_cur = ctl_i.clear ? '0 : idx_q;

  always_comb begin
    idx_nx = idx_cur;
    if (idx_cur < TE_LEN) begin
      if (lower_byte(data_i) == te_char(idx_cur)) begin
        idx_nx = idx_cur + 5'd1;
      end else begin
        // Restart, keeping a CR as the first matched byte
        idx_nx = (data_i == CH_CR) ? 5'd1 : 5'd0;
      end
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (ctl_i.fire) begin
      idx_d = ctl_i.scan_en ? idx_nx : idx_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  assign seen_d_o = (idx_d >= TE_LEN);

endmodule

`default_nettype wire

[sim/tb_http_request_length_framer.sv]
// Self-checking testbench of the HTTP request length framer: byte streams against a predictor.
module tb_http_request_length_framer import hrlf_pkg::*; ();

  localparam int unsigned CLK_HALF     = 5;
  localparam int unsigned RESET_CYCLES = 6;
  // Two register stages between a byte and its result, plus margin.
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned HOLD_CYCLES   = 80;

  localparam logic [23:0] LIMIT_AT_RESET = 24'd1048576;
  localparam logic [23:0] LIMIT_MIN      = 24'd16;
  localparam logic [23:0] LIMIT_MAX      = 24'hFFFFFF;

  localparam logic [7:0] CR        = 8'h0D;
  localparam logic [7:0] LF        = 8'h0A;
  localparam logic [7:0] SP        = 8'h20;
  localparam logic [7:0] TAB       = 8'h09;
  localparam logic [7:0] PLUS      = 8'h2B;
  localparam logic [7:0] MINUS     = 8'h2D;
  localparam logic [7:0] ZERO      = 8'h30;
  localparam logic [7:0] NINE      = 8'h39;
  localparam logic [7:0] UPPER_A   = 8'h41;
  localparam logic [7:0] UPPER_Z   = 8'h5A;
  localparam logic [7:0] LOWER_A   = 8'h61;
  localparam logic [7:0] LOWER_Z   = 8'h7A;
  localparam logic [7:0] LETTER_X  = 8'h78;
  localparam logic [7:0] CASE_FLIP = 8'h20;

  localparam logic [8*15-1:0] CL_WORD = "content-length:";
  localparam logic [8*17-1:0] TE_WORD = "transfer-encoding";

  // Line scan positions: below LINE_BLANKS the value is the match position in CL_WORD.
  localparam logic [4:0] LINE_HOME   = 5'd0;
  localparam logic [4:0] LINE_BLANKS = 5'd15;
  localparam logic [4:0] LINE_SIGN   = 5'd16;
  localparam logic [4:0] LINE_DIGITS = 5'd17;
  localparam logic [4:0] LINE_REST   = 5'd18;
  // CR LF plus the 17 characters of the encoding header name.
  localparam logic [4:0] TE_MATCHED  = 5'd19;

  typedef enum logic [1:0] {
    PH_HEADERS,
    PH_BODY,
    PH_FINISHED
  } frame_phase_e;

  typedef struct packed {
    hrlf_status_e      status;
    logic [CLEN_W-1:0] length_value;
    logic [HLEN_W-1:0] header_length;
  } frame_result_t;

  logic clk;
  logic rst_n;

  hrlf_in_if  in_if ();
  hrlf_out_if out_if ();
  hrlf_cfg_if cfg_if ();

  http_request_length_framer uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  // Predictor state
  logic [23:0]  size_limit;
  logic [23:0]  req_bytes_seen;
  frame_phase_e parse_phase;
  logic [1:0]   crlf_match;
  logic [4:0]   line_pos;
  logic [31:0]  len_acc;
  logic         len_has_digit;
  logic         len_found;
  logic [31:0]  len_first;
  logic         len_conflict;
  logic [4:0]   te_pos;
  logic [23:0]  hdr_end;

  frame_result_t framer_results_q[$];

  // Stimulus being assembled
  logic [7:0] stream_bytes[$];
  logic       stream_sor[$];
  logic       sor_pending;

  int unsigned bytes_sent;
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned rx_hold;
  int unsigned rx_gap;
  logic        tx_idle_en;
  logic        rx_idle_en;

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------- predictor

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= UPPER_A && c <= UPPER_Z) ? (c | CASE_FLIP) : c;
  endfunction

  function automatic logic [7:0] te_char_at(input logic [4:0] pos);
    if (pos == 5'd0) return CR;
    if (pos == 5'd1) return LF;
    return TE_WORD[8*(16-(pos-2)) +: 8];
  endfunction

  function automatic void clear_frame();
    req_bytes_seen = '0;
    parse_phase    = PH_HEADERS;
    crlf_match     = 2'd0;
    line_pos       = LINE_HOME;
    len_acc        = '0;
    len_has_digit  = 1'b0;
    len_found      = 1'b0;
    len_first      = '0;
    len_conflict   = 1'b0;
    te_pos         = 5'd0;
    hdr_end        = '0;
  endfunction

  function automatic void commit_length();
    if (len_has_digit) begin
      if (!len_found) begin
        len_first = len_acc;
        len_found = 1'b1;
      end else if (len_first != len_acc) begin
        len_conflict = 1'b1;
      end
    end
  endfunction

  function automatic void scan_line(input logic [7:0] b, input logic after_cr);
    logic [4:0]  s;
    logic [63:0] d;
    s = line_pos;
    d = {56'd0, b - ZERO};
    if (s < LINE_BLANKS) begin
      if (to_lower(b) == CL_WORD[8*(14-s) +: 8]) begin
        s = s + 5'd1;
        if (s == LINE_BLANKS) begin
          len_acc       = '0;
          len_has_digit = 1'b0;
        end
      end else begin
        s = LINE_REST;
      end
    end else if (s == LINE_BLANKS || s == LINE_SIGN || s == LINE_DIGITS) begin
      if (b >= ZERO && b <= NINE) begin
        // saturate at the largest 32-bit value
        if ({32'd0, len_acc} > (64'h0000_0000_FFFF_FFFF - d) / 64'd10) begin
          len_acc = 32'hFFFF_FFFF;
        end else begin
          len_acc = len_acc * 32'd10 + d[31:0];
        end
        len_has_digit = 1'b1;
        s = LINE_DIGITS;
      end else if (s == LINE_BLANKS && (b == SP || b == TAB)) begin
        s = LINE_BLANKS;
      end else if (s == LINE_BLANKS && b == PLUS) begin
        s = LINE_SIGN;
      end else begin
        if (s == LINE_DIGITS) commit_length();
        s = LINE_REST;
      end
    end else begin
      s = LINE_REST;
    end
    if (b == LF && after_cr) s = LINE_HOME;
    line_pos = s;
  endfunction

  function automatic void scan_encoding(input logic [7:0] b);
    if (te_pos < TE_MATCHED) begin
      if (to_lower(b) == te_char_at(te_pos)) te_pos = te_pos + 5'd1;
      else te_pos = (b == CR) ? 5'd1 : 5'd0;
    end
  endfunction

  // Advance the predictor by one byte and return the answer for it.
  function automatic frame_result_t frame_step(input logic [7:0] b, input logic sor);
    frame_result_t r;
    logic [24:0]   n;
    logic [23:0]   body_n;
    logic [63:0]   room;
    logic          after_cr;
    logic          hdr_done;
    r.status = ST_NEED_MORE;
    if (sor) clear_frame();
    if (parse_phase == PH_FINISHED) begin
      r.status = ST_IGNORED;
    end else begin
      n = {1'b0, req_bytes_seen} + 25'd1;
      if (n > {1'b0, size_limit}) begin
        r.status    = ST_TOO_LARGE;
        parse_phase = PH_FINISHED;
      end else begin
        req_bytes_seen = n[23:0];
        if (parse_phase == PH_HEADERS) begin
          after_cr = crlf_match[0];
          hdr_done = 1'b0;
          scan_line(b, after_cr);
          scan_encoding(b);
          if (b == CR) begin
            crlf_match = (crlf_match == 2'd2) ? 2'd3 : 2'd1;
          end else if (b == LF && crlf_match == 2'd1) begin
            crlf_match = 2'd2;
          end else if (b == LF && crlf_match == 2'd3) begin
            crlf_match = 2'd0;
            hdr_done   = 1'b1;
          end else begin
            crlf_match = 2'd0;
          end
          if (hdr_done) begin
            hdr_end     = n[23:0];
            parse_phase = PH_FINISHED;
            room        = {40'd0, size_limit} - {39'd0, n};
            if (len_conflict) begin
              r.status = ST_CONFLICT;
            end else if (te_pos >= TE_MATCHED) begin
              r.status = ST_ENCODING;
            end else if (len_found && {32'd0, len_first} > room) begin
              r.status = ST_TOO_LARGE;
            end else if (!len_found || len_first == 32'd0) begin
              r.status = ST_COMPLETE;
            end else begin
              parse_phase = PH_BODY;
            end
          end
        end else begin
          body_n = n[23:0] - hdr_end;
          if ({8'd0, body_n} >= len_first) begin
            r.status    = ST_COMPLETE;
            parse_phase = PH_FINISHED;
          end
        end
      end
    end
    r.length_value  = len_found ? len_first : '0;
    r.header_length = hdr_end;
    return r;
  endfunction

  // ---------------------------------------------------------------- stream assembly

  function automatic logic [7:0] random_case(input logic [7:0] c);
    if (((c >= LOWER_A && c <= LOWER_Z) || (c >= UPPER_A && c <= UPPER_Z))
        && $urandom_range(0, 1) == 1) begin
      return c ^ CASE_FLIP;
    end
    return c;
  endfunction

  function automatic void begin_request();
    sor_pending = 1'b1;
  endfunction

  function automatic void put_byte(input logic [7:0] b);
    stream_bytes.push_back(b);
    stream_sor.push_back(sor_pending);
    sor_pending = 1'b0;
  endfunction

  function automatic void put_text(input string s, input logic mixed_case);
    for (int i = 0; i < s.len(); i++) begin
      put_byte(mixed_case ? random_case(s[i]) : s[i]);
    end
  endfunction

  function automatic void put_crlf();
    put_byte(CR);
    put_byte(LF);
  endfunction

  function automatic void put_random(input int unsigned count);
    repeat (count) put_byte(8'($urandom_range(0, 255)));
  endfunction

  // Content-Length line with random framing; some variants yield no value.
  function automatic void put_length_line(input logic [31:0] val);
    int unsigned pick;
    int unsigned n_digits;
    pick = $urandom_range(0, 19);
    if ($urandom_range(0, 9) == 0) put_text("Content-Lenght:", 1);
    else put_text("Content-Length:", 1);
    repeat ($urandom_range(0, 2)) put_byte(($urandom_range(0, 1) == 1) ? SP : TAB);
    if (pick == 0) put_byte(MINUS);
    else if (pick == 1) put_byte(LETTER_X);
    else if (pick <= 4) put_byte(PLUS);
    if (pick == 5) begin
      // long enough to saturate most of the time
      n_digits = $urandom_range(9, 13);
      repeat (n_digits) put_byte(ZERO + 8'($urandom_range(0, 9)));
    end else if (pick != 6) begin
      put_text($sformatf("%0d", val), 1'b0);
    end
    if ($urandom_range(0, 5) == 0) put_text(" ;q", 1'b0);
    if ($urandom_range(0, 7) == 0) begin
      // bare LF, then digits that must not extend the value
      put_byte(LF);
      put_byte(ZERO + 8'($urandom_range(0, 9)));
    end
    put_crlf();
  endfunction

  // Mostly well-formed requests with random content; the rest is noise.
  function automatic void build_request();
    int unsigned first_idx;
    int unsigned lines;
    int unsigned body_len;
    int unsigned kind;
    logic [31:0] req_len;
    logic        well_formed;
    first_idx   = stream_bytes.size();
    well_formed = ($urandom_range(0, 9) < 7);
    if ($urandom_range(0, 3) == 0) req_len = $urandom_range(0, 2000);
    else req_len = $urandom_range(0, 20);
    begin_request();
    kind = $urandom_range(0, 7);
    // the encoding header on the first line is not preceded by CR LF
    if (kind == 0) put_text("Transfer-Encoding: gzip", 1);
    else if (kind == 1) put_random($urandom_range(1, 6));
    else if (kind != 2) put_text("GET /a HTTP/1.1", 0);
    put_crlf();
    if (well_formed) begin
      if ($urandom_range(0, 3) != 0) begin
        put_text("Host: h", 0);
        put_crlf();
      end
      repeat ($urandom_range(0, 2)) begin
        put_text("Content-Length:", 1);
        put_byte(SP);
        put_text($sformatf("%0d", req_len), 0);
        put_crlf();
      end
    end else begin
      lines = $urandom_range(1, 4);
      repeat (lines) begin
        case ($urandom_range(0, 4))
          0, 1: put_length_line(($urandom_range(0, 1) == 1) ? req_len : $urandom_range(0, 30));
          2: begin
            put_text("Transfer-Encoding: chunked", 1);
            put_crlf();
          end
          3: begin
            put_random($urandom_range(1, 8));
            put_crlf();
          end
          default: begin
            put_text("X-Y: z", 0);
            put_crlf();
          end
        endcase
      end
    end
    if ($urandom_range(0, 9) != 0) put_crlf();
    body_len = (req_len <= 24) ? req_len : $urandom_range(0, 6);
    put_random(body_len + $urandom_range(0, 2));
    if (!well_formed && $urandom_range(0, 3) == 0) begin
      stream_sor[$urandom_range(first_idx + 1, stream_bytes.size() - 1)] = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------- channel drivers

  task automatic send_byte(input logic [7:0] b, input logic sor);
    int unsigned gap;
    gap = 0;
    if (tx_idle_en && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 7);
    if (gap > 0) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_if.valid            <= 1'b1;
    in_if.data_byte        <= b;
    in_if.start_of_request <= sor;
    do @(posedge clk); while (!in_if.ready);
    framer_results_q.push_back(frame_step(b, sor));
    bytes_sent++;
  endtask

  task automatic send_stream();
    foreach (stream_bytes[i]) send_byte(stream_bytes[i], stream_sor[i]);
    stream_bytes.delete();
    stream_sor.delete();
  endtask

  // Drop valid and hold until every answer is back and the pipeline is empty.
  task automatic wait_idle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (framer_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_size_limit(input logic [23:0] limit);
    @(negedge clk);
    cfg_if.valid        <= 1'b1;
    cfg_if.req_size_max <= limit;
    do @(posedge clk); while (!cfg_if.ready);
    size_limit = limit;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // Result sink: random stall bursts, plus a long hold on request.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_if.ready <= 1'b0;
        rx_hold--;
      end else if (rx_gap > 0) begin
        out_if.ready <= 1'b0;
        rx_gap--;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        rx_gap = $urandom_range(0, 6);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Compare each result beat with the oldest prediction.
  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (framer_results_q.size() == 0) begin
        $error("unexpected result beat: status %0d", out_if.status);
        fail_count++;
      end else begin
        want = framer_results_q.pop_front();
        if (out_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_if.status);
          fail_count++;
        end
        if (out_if.length_value !== want.length_value) begin
          $error("length_value: expected %0d, got %0d", want.length_value,
                 out_if.length_value);
          fail_count++;
        end
        if (out_if.header_length !== want.header_length) begin
          $error("header_length: expected %0d, got %0d", want.header_length,
                 out_if.header_length);
          fail_count++;
        end
      end
    end
  end

  // Run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------- tests

  // Short hand-built requests covering every answer but a conflict, and the smallest limit.
  task automatic test_directed();
    // empty header section, then a byte past the answer
    begin_request();
    put_crlf();
    put_crlf();
    put_byte(8'h5A);
    // plus sign, body bytes at both data extremes
    begin_request();
    put_crlf();
    put_text("Content-Length:+2", 0);
    put_crlf();
    put_crlf();
    put_byte(8'h00);
    put_byte(8'hFF);
    // encoding header after CR LF
    begin_request();
    put_crlf();
    put_text("TRANSFER-ENCODING", 0);
    put_crlf();
    put_crlf();
    send_stream();
    wait_idle();
    write_size_limit(LIMIT_MIN);
    // header section alone exceeds the limit
    begin_request();
    put_text("Content-Length:9", 0);
    put_crlf();
    put_crlf();
    put_byte(8'h41);
    send_stream();
  endtask

  task automatic test_random_traffic(input logic [23:0] limit, input int unsigned n_bytes);
    int unsigned stop_at;
    wait_idle();
    write_size_limit(limit);
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      build_request();
      send_stream();
    end
  endtask

  // Pause the sender until every answer is back, then resume.
  task automatic test_sender_pause();
    wait_idle();
    write_size_limit(24'($urandom_range(40, 120)));
    build_request();
    send_stream();
    wait_idle();
    build_request();
    send_stream();
  endtask

  // Hold the sink for a long stretch while bytes keep coming.
  task automatic test_receiver_hold();
    wait_idle();
    tx_idle_en = 1'b0;
    rx_hold    = HOLD_CYCLES;
    build_request();
    build_request();
    send_stream();
    tx_idle_en = 1'b1;
  endtask

  task automatic test_no_idle();
    wait_idle();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    test_random_traffic(24'($urandom_range(100, 400)), 100);
  endtask

  initial begin
    rst_n                  = 1'b0;
    in_if.valid            = 1'b0;
    in_if.data_byte        = '0;
    in_if.start_of_request = 1'b0;
    cfg_if.valid           = 1'b0;
    cfg_if.req_size_max    = '0;
    tx_idle_en             = 1'b1;
    rx_idle_en             = 1'b1;
    rx_hold                = 0;
    rx_gap                 = 0;
    bytes_sent             = 0;
    fail_count             = 0;
    sor_pending            = 1'b0;
    size_limit             = LIMIT_AT_RESET;
    clear_frame();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random_traffic(LIMIT_AT_RESET, 120);
    test_random_traffic(LIMIT_MAX, 120);
    test_sender_pause();
    repeat (3) test_random_traffic(24'($urandom_range(16, 120)), 60);
    test_receiver_hold();
    test_no_idle();
    wait_idle();

    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
